@@ rtl/ile_pkg.sv @@
// Shared constants, codes and controller/datapath link types for the list engine.
`default_nettype none
package ile_pkg;

    localparam int LIST_DEPTH = 64;
    localparam int WORD_W     = 64;
    localparam int POS_W      = 6;
    localparam int CNT_W      = 7;
    localparam int ACT_W      = 2;
    localparam int ST_W       = 2;

    typedef enum logic [ACT_W-1:0] {
        ACT_READ   = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_FIND   = 2'd2,
        ACT_REMOVE = 2'd3
    } action_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK       = 2'd0,
        ST_RANGE    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_RWAIT,
        S_SHIFT,
        S_DRAIN,
        S_PUT,
        S_FIND,
        S_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic    load;
        logic    rd_pos;
        logic    shift_init;
        logic    shift_rd;
        logic    find_init;
        logic    find_rd;
        logic    put;
        logic    fin;
        status_t fin_st;
        logic    emit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        action_t act;
        logic    pos_ge_cnt;
        logic    pos_gt_cnt;
        logic    full;
        logic    pos_eq_cnt;
        logic    pos_last;
        logic    shift_last;
        logic    scan_more;
        logic    cmp_valid;
        logic    hit;
        logic    out_free;
    } stat_t;

endpackage
`default_nettype wire

@@ rtl/ile_req_if.sv @@
// Request channel: action, position and word with valid/ready.
`default_nettype none
interface ile_req_if;
    logic                     valid;
    logic                     ready;
    logic [ile_pkg::ACT_W-1:0]  action;
    logic [ile_pkg::POS_W-1:0]  position;
    logic [ile_pkg::WORD_W-1:0] word;

    modport source (output valid, output action, output position, output word, input ready);
    modport sink   (input valid, input action, input position, input word, output ready);
endinterface
`default_nettype wire

@@ rtl/ile_rsp_if.sv @@
// Response channel: read word, found position, entry count and status with valid/ready.
`default_nettype none
interface ile_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [ile_pkg::WORD_W-1:0] read_word;
    logic [ile_pkg::POS_W-1:0]  found_position;
    logic [ile_pkg::CNT_W-1:0]  entry_count;
    logic [ile_pkg::ST_W-1:0]   status;

    modport source (output valid, output read_word, output found_position,
                    output entry_count, output status, input ready);
    modport sink   (input valid, input read_word, input found_position,
                    input entry_count, input status, output ready);
endinterface
`default_nettype wire

@@ rtl/ile_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ile_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

@@ rtl/ile_ctrl.sv @@
// Request sequencer: decodes each request and steps the datapath through it.
`default_nettype none
module ile_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_ready,
    input  wire ile_pkg::stat_t stat,
    output ile_pkg::cmd_t       cmd
);

    ile_pkg::state_t state_reg;
    ile_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ile_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.fin_st = ile_pkg::ST_OK;
        req_ready  = 1'b0;

        case (state_reg)
            ile_pkg::S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ile_pkg::S_EVAL;
                end
            end

            ile_pkg::S_EVAL:
            begin
                case (stat.act)
                    ile_pkg::ACT_READ:
                    begin
                        if (stat.pos_ge_cnt)
                        begin
                            cmd.fin    = 1'b1;
                            cmd.fin_st = ile_pkg::ST_RANGE;
                            state_next = ile_pkg::S_DONE;
                        end
                        else
                        begin
                            cmd.rd_pos = 1'b1;
                            state_next = ile_pkg::S_RWAIT;
                        end
                    end
                    ile_pkg::ACT_INSERT:
                    begin
                        if (stat.pos_gt_cnt)
                        begin
                            cmd.fin    = 1'b1;
                            cmd.fin_st = ile_pkg::ST_RANGE;
                            state_next = ile_pkg::S_DONE;
                        end
                        else if (stat.full)
                        begin
                            cmd.fin    = 1'b1;
                            cmd.fin_st = ile_pkg::ST_FULL;
                            state_next = ile_pkg::S_DONE;
                        end
                        else if (stat.pos_eq_cnt)
                        begin
                            state_next = ile_pkg::S_PUT;
                        end
                        else
                        begin
                            cmd.shift_init = 1'b1;
                            state_next     = ile_pkg::S_SHIFT;
                        end
                    end
                    ile_pkg::ACT_FIND:
                    begin
                        cmd.find_init = 1'b1;
                        state_next    = ile_pkg::S_FIND;
                    end
                    default:
                    begin
                        if (stat.pos_ge_cnt)
                        begin
                            cmd.fin    = 1'b1;
                            cmd.fin_st = ile_pkg::ST_RANGE;
                            state_next = ile_pkg::S_DONE;
                        end
                        else if (stat.pos_last)
                        begin
                            // last entry: drop it without moving anything
                            cmd.fin    = 1'b1;
                            state_next = ile_pkg::S_DONE;
                        end
                        else
                        begin
                            cmd.shift_init = 1'b1;
                            state_next     = ile_pkg::S_SHIFT;
                        end
                    end
                endcase
            end

            ile_pkg::S_RWAIT:
            begin
                cmd.fin    = 1'b1;
                state_next = ile_pkg::S_DONE;
            end

            ile_pkg::S_SHIFT:
            begin
                cmd.shift_rd = 1'b1;
                if (stat.shift_last)
                begin
                    state_next = ile_pkg::S_DRAIN;
                end
            end

            ile_pkg::S_DRAIN:
            begin
                // the datapath retires the last moved entry here
                if (stat.act == ile_pkg::ACT_INSERT)
                begin
                    state_next = ile_pkg::S_PUT;
                end
                else
                begin
                    cmd.fin    = 1'b1;
                    state_next = ile_pkg::S_DONE;
                end
            end

            ile_pkg::S_PUT:
            begin
                cmd.put    = 1'b1;
                cmd.fin    = 1'b1;
                state_next = ile_pkg::S_DONE;
            end

            ile_pkg::S_FIND:
            begin
                if (stat.hit)
                begin
                    cmd.fin    = 1'b1;
                    state_next = ile_pkg::S_DONE;
                end
                else if (!stat.scan_more && !stat.cmp_valid)
                begin
                    cmd.fin    = 1'b1;
                    cmd.fin_st = ile_pkg::ST_NOTFOUND;
                    state_next = ile_pkg::S_DONE;
                end
                else
                begin
                    cmd.find_rd = stat.scan_more;
                end
            end

            ile_pkg::S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ile_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = ile_pkg::S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/ile_dp.sv @@
// Datapath: entry memory, count, shift and scan counters, result and output registers.
`default_nettype none
module ile_dp (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [ile_pkg::ACT_W-1:0]  action,
    input  wire logic [ile_pkg::POS_W-1:0]  position,
    input  wire logic [ile_pkg::WORD_W-1:0] word,
    input  wire ile_pkg::cmd_t              cmd,
    output ile_pkg::stat_t                  stat,
    ile_rsp_if.source                       rsp
);

    localparam int POS_W  = ile_pkg::POS_W;
    localparam int CNT_W  = ile_pkg::CNT_W;
    localparam int WORD_W = ile_pkg::WORD_W;

    // request
    ile_pkg::action_t    act_reg;
    logic [POS_W-1:0]    pos_reg;
    logic [WORD_W-1:0]   word_reg;

    // list state and walkers
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [CNT_W-1:0]    idx_reg;
    logic [CNT_W-1:0]    idx_next;
    logic                wr_pending_reg;
    logic [POS_W-1:0]    wr_idx_reg;
    logic                cmp_valid_reg;
    logic [POS_W-1:0]    cmp_idx_reg;

    // staged result and output beat
    logic [WORD_W-1:0]   res_rd_reg;
    logic [POS_W-1:0]    res_fpos_reg;
    ile_pkg::status_t    res_st_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [WORD_W-1:0]   out_rd_reg;
    logic [POS_W-1:0]    out_fpos_reg;
    logic [CNT_W-1:0]    out_cnt_reg;
    ile_pkg::status_t    out_st_reg;

    logic [CNT_W-1:0]    pos_ext;
    logic                is_insert;
    logic                fin_ok;
    logic                ram_we;
    logic [POS_W-1:0]    ram_waddr;
    logic [WORD_W-1:0]   ram_wdata;
    logic [POS_W-1:0]    ram_raddr;
    logic [WORD_W-1:0]   ram_rdata;

    assign pos_ext   = {1'b0, pos_reg};
    assign is_insert = (act_reg == ile_pkg::ACT_INSERT);
    assign fin_ok    = cmd.fin && (cmd.fin_st == ile_pkg::ST_OK);

    assign ram_we    = wr_pending_reg || cmd.put;
    assign ram_waddr = cmd.put ? pos_reg : wr_idx_reg;
    assign ram_wdata = cmd.put ? word_reg : ram_rdata;
    assign ram_raddr = cmd.rd_pos ? pos_reg : idx_reg[POS_W-1:0];

    ile_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ile_pkg::LIST_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        stat.act        = act_reg;
        stat.pos_ge_cnt = (pos_ext >= count_reg);
        stat.pos_gt_cnt = (pos_ext > count_reg);
        stat.full       = (count_reg == CNT_W'(ile_pkg::LIST_DEPTH));
        stat.pos_eq_cnt = (pos_ext == count_reg);
        stat.pos_last   = (CNT_W'(pos_ext + CNT_W'(1)) == count_reg);
        stat.shift_last = is_insert ? (idx_reg == pos_ext)
                                    : (CNT_W'(idx_reg + CNT_W'(1)) == count_reg);
        stat.scan_more  = (idx_reg < count_reg);
        stat.cmp_valid  = cmp_valid_reg;
        stat.hit        = cmp_valid_reg && (ram_rdata == word_reg);
        stat.out_free   = !out_valid_reg || rsp.ready;
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.shift_init)
        begin
            idx_next = is_insert ? CNT_W'(count_reg - CNT_W'(1))
                                 : CNT_W'(pos_ext + CNT_W'(1));
        end
        else if (cmd.find_init)
        begin
            idx_next = '0;
        end
        else if (cmd.shift_rd)
        begin
            idx_next = is_insert ? CNT_W'(idx_reg - CNT_W'(1))
                                 : CNT_W'(idx_reg + CNT_W'(1));
        end
        else if (cmd.find_rd)
        begin
            idx_next = CNT_W'(idx_reg + CNT_W'(1));
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (fin_ok && is_insert)
        begin
            count_next = CNT_W'(count_reg + CNT_W'(1));
        end
        else if (fin_ok && (act_reg == ile_pkg::ACT_REMOVE))
        begin
            count_next = CNT_W'(count_reg - CNT_W'(1));
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            wr_pending_reg <= 1'b0;
            cmp_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            wr_pending_reg <= cmd.shift_rd;
            cmp_valid_reg  <= cmd.find_rd;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg  <= ile_pkg::action_t'(action);
            pos_reg  <= position;
            word_reg <= word;
        end
        idx_reg     <= idx_next;
        // moved entry lands one above (insert) or one below (remove) its source
        wr_idx_reg  <= is_insert ? POS_W'(idx_reg[POS_W-1:0] + POS_W'(1))
                                 : POS_W'(idx_reg[POS_W-1:0] - POS_W'(1));
        cmp_idx_reg <= idx_reg[POS_W-1:0];
        if (cmd.fin)
        begin
            res_st_reg   <= cmd.fin_st;
            res_rd_reg   <= (fin_ok && (act_reg == ile_pkg::ACT_READ)) ? ram_rdata : '0;
            res_fpos_reg <= (fin_ok && (act_reg == ile_pkg::ACT_FIND)) ? cmp_idx_reg : '0;
        end
        if (cmd.emit)
        begin
            out_rd_reg   <= res_rd_reg;
            out_fpos_reg <= res_fpos_reg;
            out_cnt_reg  <= count_reg;
            out_st_reg   <= res_st_reg;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.read_word      = out_rd_reg;
    assign rsp.found_position = out_fpos_reg;
    assign rsp.entry_count    = out_cnt_reg;
    assign rsp.status         = out_st_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(ile_pkg::LIST_DEPTH))
        else $error("entry count above list depth");

    a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.put && wr_pending_reg))
        else $error("shift write and word write in the same cycle");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> stat.out_free)
        else $error("result beat would overwrite an untaken beat");

    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.fin |=> (count_reg == $past(count_reg)))
        else $error("entry count changed outside request completion");

endmodule
`default_nettype wire

@@ rtl/indexed_list_engine_unit.sv @@
// Top level of the indexed list engine: sequencer plus datapath.
//
//  channel | dir | beat contents                                  | handshake
//  --------+-----+------------------------------------------------+-----------
//  req     | in  | action, position, word                         | valid/ready
//  rsp     | out | read_word, found_position, entry_count, status | valid/ready
//
// One request at a time. A read looks up the entry; a rejected request or a remove
// of the last entry finishes without touching the store; find scans from entry 0 up
// to the first hit; insert and remove first move the entries above the position.
// Moves and searches walk the 64-entry store one entry per cycle through its
// single read and single write port; that walk sets the cost of long requests.
// A held rsp beat adds the cycles it waits on rsp.ready before the next result leaves.
// Reset clears the count and all handshake state; the store itself is not cleared.
// A response waiting on rsp.ready does not stop the next request being accepted.
`default_nettype none
module indexed_list_engine_unit (
    input  wire logic clk,
    input  wire logic rst_n,
    ile_req_if.sink   req,
    ile_rsp_if.source rsp
);

    ile_pkg::cmd_t  cmd;
    ile_pkg::stat_t stat;
    logic           ready;

    assign req.ready = ready;

    ile_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    ile_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .action   (req.action),
        .position (req.position),
        .word     (req.word),
        .cmd      (cmd),
        .stat     (stat),
        .rsp      (rsp)
    );

endmodule
`default_nettype wire

@@ bench/indexed_list_engine_unit_tb.sv @@
// Self-checking bench for the indexed list engine: random read/insert/find/remove traffic.
`timescale 1ns / 1ps
module indexed_list_engine_unit_tb;

    localparam int QUIET_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 80;
    localparam int ITEMS_PER_PHASE = 150;

    localparam int WORD_W     = ile_pkg::WORD_W;
    localparam int POS_W      = ile_pkg::POS_W;
    localparam int CNT_W      = ile_pkg::CNT_W;
    localparam int ST_W       = ile_pkg::ST_W;
    localparam int LIST_DEPTH = ile_pkg::LIST_DEPTH;

    typedef struct {
        logic [WORD_W-1:0] read_word;
        logic [POS_W-1:0]  found_position;
        logic [CNT_W-1:0]  entry_count;
        ile_pkg::status_t  status;
    } list_result_t;

    class list_scoreboard;
        logic [WORD_W-1:0] entries [LIST_DEPTH];
        int held;
        list_result_t pending_results [$];
        int errors;

        function new();
            held = 0;
            errors = 0;
        endfunction

        task report(string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            errors++;
        endtask

        // Apply one accepted request to the shadow list and queue its result.
        function void note_request(ile_pkg::action_t act, logic [POS_W-1:0] pos,
                                   logic [WORD_W-1:0] w);
            list_result_t r;
            int k;
            r.read_word = '0;
            r.found_position = '0;
            r.status = ile_pkg::ST_OK;
            case (act)
                ile_pkg::ACT_READ:
                    if (pos < held)
                        r.read_word = entries[pos];
                    else
                        r.status = ile_pkg::ST_RANGE;
                ile_pkg::ACT_INSERT:
                    if (pos > held)
                        r.status = ile_pkg::ST_RANGE;
                    else if (held >= LIST_DEPTH)
                        r.status = ile_pkg::ST_FULL;
                    else
                    begin
                        for (k = held; k > pos; k--)
                            entries[k] = entries[k - 1];
                        entries[pos] = w;
                        held++;
                    end
                ile_pkg::ACT_FIND:
                begin
                    r.status = ile_pkg::ST_NOTFOUND;
                    for (k = 0; k < held; k++)
                    begin
                        if (r.status == ile_pkg::ST_NOTFOUND && entries[k] === w)
                        begin
                            r.found_position = k[POS_W-1:0];
                            r.status = ile_pkg::ST_OK;
                        end
                    end
                end
                default:
                    if (pos >= held)
                        r.status = ile_pkg::ST_RANGE;
                    else
                    begin
                        for (k = pos; k + 1 < held; k++)
                            entries[k] = entries[k + 1];
                        held--;
                    end
            endcase
            r.entry_count = held[CNT_W-1:0];
            pending_results.push_back(r);
        endfunction

        task check_response(logic [WORD_W-1:0] rd, logic [POS_W-1:0] fpos,
                            logic [CNT_W-1:0] cnt, logic [ST_W-1:0] st);
            list_result_t r;
            if (pending_results.size() == 0)
            begin
                report("response beat with no request outstanding");
                return;
            end
            r = pending_results.pop_front();
            if (rd !== r.read_word)
                report($sformatf("read_word %h, want %h", rd, r.read_word));
            if (fpos !== r.found_position)
                report($sformatf("found_position %0d, want %0d", fpos, r.found_position));
            if (cnt !== r.entry_count)
                report($sformatf("entry_count %0d, want %0d", cnt, r.entry_count));
            if (st !== r.status)
                report($sformatf("status %0d, want %s", st, r.status.name()));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;

    ile_req_if req_ch ();
    ile_rsp_if rsp_ch ();

    indexed_list_engine_unit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    list_scoreboard board = new();
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int quiet_cycles = 0;
    bit growing = 1'b1;

    logic [WORD_W-1:0] word_pool [6] = '{
        64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
        64'h0000_0000_0000_0001, 64'h7FF8_0000_0000_0000, 64'hA5A5_5A5A_0F0F_F0F0
    };

    task send_request(ile_pkg::action_t act, logic [POS_W-1:0] pos, logic [WORD_W-1:0] w);
        if ($urandom_range(99) < sender_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < sender_idle_pct);
        end
        req_ch.valid    <= 1'b1;
        req_ch.action   <= act;
        req_ch.position <= pos;
        req_ch.word     <= w;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        board.note_request(act, pos, w);
    endtask

    function logic [WORD_W-1:0] fresh_word();
        if ($urandom_range(99) < 35)
            return word_pool[$urandom_range(5)];
        return {$urandom, $urandom};
    endfunction

    task random_request();
        ile_pkg::action_t act;
        logic [POS_W-1:0] pos;
        logic [WORD_W-1:0] w;
        int roll;
        int n;
        n = board.held;
        roll = $urandom_range(99);
        // Lean toward growth or shrinkage so the list swings between empty and full.
        if (growing)
            act = roll < 62 ? ile_pkg::ACT_INSERT : roll < 74 ? ile_pkg::ACT_REMOVE :
                  roll < 87 ? ile_pkg::ACT_READ : ile_pkg::ACT_FIND;
        else
            act = roll < 62 ? ile_pkg::ACT_REMOVE : roll < 74 ? ile_pkg::ACT_INSERT :
                  roll < 87 ? ile_pkg::ACT_READ : ile_pkg::ACT_FIND;
        case (act)
            ile_pkg::ACT_INSERT:
                if ($urandom_range(99) < 88)
                    pos = POS_W'($urandom_range(n < LIST_DEPTH ? n : LIST_DEPTH - 1));
                else
                    pos = POS_W'($urandom_range(LIST_DEPTH - 1));
            ile_pkg::ACT_FIND:
                pos = POS_W'($urandom_range(LIST_DEPTH - 1));
            default:
                if (n > 0 && $urandom_range(99) < 85)
                    pos = POS_W'($urandom_range(n - 1));
                else
                    pos = POS_W'($urandom_range(LIST_DEPTH - 1));
        endcase
        if (act == ile_pkg::ACT_FIND && n > 0 && $urandom_range(99) < 55)
            w = board.entries[$urandom_range(n - 1)];
        else
            w = fresh_word();
        send_request(act, pos, w);
        // Linger a few beats at each end before turning around.
        if (board.held == LIST_DEPTH && $urandom_range(99) < 20)
            growing = 1'b0;
        else if (board.held == 0 && $urandom_range(99) < 30)
            growing = 1'b1;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            board.check_response(rsp_ch.read_word, rsp_ch.found_position,
                                 rsp_ch.entry_count, rsp_ch.status);
        rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: no beat for %0d cycles", QUIET_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        int phase;
        int i;
        rst_n           <= 1'b0;
        req_ch.valid    <= 1'b0;
        req_ch.action   <= ile_pkg::ACT_READ;
        req_ch.position <= '0;
        req_ch.word     <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty list corners first, then edges of a short list.
        send_request(ile_pkg::ACT_READ,   6'd0,  64'h0);
        send_request(ile_pkg::ACT_REMOVE, 6'd0,  64'h0);
        send_request(ile_pkg::ACT_FIND,   6'd0,  64'h0);
        send_request(ile_pkg::ACT_INSERT, 6'd1,  64'h1234);
        send_request(ile_pkg::ACT_INSERT, 6'd63, 64'h1234);
        send_request(ile_pkg::ACT_INSERT, 6'd0,  64'hFFFF_FFFF_FFFF_FFFF);
        send_request(ile_pkg::ACT_INSERT, 6'd1,  64'h0);
        send_request(ile_pkg::ACT_INSERT, 6'd0,  64'h8000_0000_0000_0000);
        send_request(ile_pkg::ACT_INSERT, 6'd3,  64'hFFFF_FFFF_FFFF_FFFF);
        send_request(ile_pkg::ACT_INSERT, 6'd5,  64'h5555);
        send_request(ile_pkg::ACT_READ,   6'd0,  64'h0);
        send_request(ile_pkg::ACT_READ,   6'd3,  64'hFFFF_FFFF_FFFF_FFFF);
        send_request(ile_pkg::ACT_READ,   6'd4,  64'h0);
        send_request(ile_pkg::ACT_READ,   6'd63, 64'h0);
        send_request(ile_pkg::ACT_FIND,   6'd63, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(ile_pkg::ACT_FIND,   6'd0,  64'h0);
        send_request(ile_pkg::ACT_FIND,   6'd0,  64'hDEAD_BEEF_0000_0001);
        send_request(ile_pkg::ACT_REMOVE, 6'd3,  64'h0);
        send_request(ile_pkg::ACT_REMOVE, 6'd3,  64'h0);
        send_request(ile_pkg::ACT_REMOVE, 6'd0,  64'h0);
        send_request(ile_pkg::ACT_REMOVE, 6'd63, 64'h0);
        send_request(ile_pkg::ACT_READ,   6'd1,  64'h0);

        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 48; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 48; end
                default: begin sender_idle_pct = 19; receiver_stall_pct = 19; end
            endcase
            for (i = 0; i < ITEMS_PER_PHASE; i++)
                random_request();
        end

        req_ch.valid <= 1'b0;
        while (board.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
